@@ rtl/rotation_matrix_to_quaternion_defines.svh @@
// assertion macros for the rotation matrix to quaternion block
`ifndef ROTATION_MATRIX_TO_QUATERNION_DEFINES_SVH
`define ROTATION_MATRIX_TO_QUATERNION_DEFINES_SVH
`ifndef SYNTHESIS
`define RMQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define RMQ_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define RMQ_ASSERT(lbl, prop, msg)
`define RMQ_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

@@ rtl/rmq_pkg.sv @@
// types and constants of the rotation matrix to quaternion block
package rmq_pkg;

  localparam int unsigned SampleWidth = 16;
  localparam int unsigned FracBits    = SampleWidth - 2;

  typedef enum logic [1:0] {
    AxisX = 2'd0,
    AxisY = 2'd1,
    AxisZ = 2'd2,
    AxisW = 2'd3
  } axis_e;

  typedef struct packed {
    logic signed [SampleWidth-1:0] m_r0_c0;
    logic signed [SampleWidth-1:0] m_r0_c1;
    logic signed [SampleWidth-1:0] m_r0_c2;
    logic signed [SampleWidth-1:0] m_r1_c0;
    logic signed [SampleWidth-1:0] m_r1_c1;
    logic signed [SampleWidth-1:0] m_r1_c2;
    logic signed [SampleWidth-1:0] m_r2_c0;
    logic signed [SampleWidth-1:0] m_r2_c1;
    logic signed [SampleWidth-1:0] m_r2_c2;
  } matrix_t;

  typedef struct packed {
    logic signed [SampleWidth-1:0] quat_x;
    logic signed [SampleWidth-1:0] quat_y;
    logic signed [SampleWidth-1:0] quat_z;
    logic signed [SampleWidth-1:0] quat_w;
    logic                          saturated;
  } quat_t;

  // cyclic successor of a vector axis
  function automatic axis_e next_axis(input axis_e a);
    axis_e n;
    unique case (a)
      AxisX:   n = AxisY;
      AxisY:   n = AxisZ;
      default: n = AxisX;
    endcase
    return n;
  endfunction

endpackage

@@ rtl/rotation_matrix_to_quaternion.sv @@
// rotation matrix (Q2.14) to unit quaternion (Q2.14), fully pipelined
//
// in_i carries the nine matrix elements under a valid/ready request; out_o
// carries x, y, z, w and a saturated flag under valid/ready. One request can
// enter every cycle while in_ready_o is high. A request passes these stages,
// W the sample width: one stage picks the main axis and radicand, W+1 stages
// form the square root one bit each, one stage forms root, half root and
// numerators, one stage flags quotient overflow, and W stages form the three
// scaled components one quotient bit each before the clip and output stage.
// Every stage holds its own valid bit and moves on when the stage after it is
// empty or moving, so bubbles close up and in_ready_o falls only when all
// stages hold a request and the receiver stalls. A stalled result is held on
// out_o unchanged. Reset clears all valid bits; the pipeline is empty after it.
`include "rotation_matrix_to_quaternion_defines.svh"

module rotation_matrix_to_quaternion (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  rmq_pkg::matrix_t in_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output rmq_pkg::quat_t  out_o
);

  localparam int unsigned W   = rmq_pkg::SampleWidth;
  localparam int unsigned F   = rmq_pkg::FracBits;
  localparam int unsigned RB  = W + 1;        // root bits
  localparam int unsigned YW  = 2 * RB;       // radicand bits
  localparam int unsigned NW  = 2 * W + 3;    // numerator and compare bits
  localparam int unsigned DW  = W + 3;        // divisor bits
  localparam int unsigned NST = 2 * W + 5;    // register stages

  localparam logic signed [W+1:0] One = (W+2)'(1) << F;
  localparam logic [W-1:0] CompMax    = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] CompMinMag = {1'b1, {(W-1){1'b0}}};

  typedef struct packed {
    logic [YW-1:0]     rem;
    logic [RB-1:0]     root;
    logic [2:0]        neg;
    logic [2:0][W:0]   mag;
    rmq_pkg::axis_e    place;
  } sq_t;

  typedef struct packed {
    logic [2:0][NW-1:0] rem;
    logic [2:0][W-1:0]  quo;
    logic [2:0]         ovf;
    logic [DW-1:0]      den;
    logic [W-1:0]       half;
    logic               zero;
    logic [2:0]         neg;
    rmq_pkg::axis_e     place;
  } dv_t;

  // handshake chain
  logic [NST:0]   ry;
  logic [NST-1:0] vq;
  logic [NST-1:0] vin;

  assign ry[NST] = out_ready_i;
  assign vin     = {vq[NST-2:0], in_valid_i};

  for (genvar s = 0; s < NST; s++) begin : g_ctl
    assign ry[s] = !vq[s] || ry[s+1];
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vq[s] <= 1'b0;
      end else if (ry[s]) begin
        vq[s] <= vin[s];
      end
    end
  end

  assign in_ready_o  = ry[0];
  assign out_valid_o = vq[NST-1];

  // front stage: trace, main axis, radicand, sums and differences
  logic signed [W+1:0] mm [3][3];
  logic signed [W+1:0] tr;
  logic signed [W+1:0] t_val;
  logic signed [W+1:0] dd [3];
  rmq_pkg::axis_e      ax, aj, ak;
  sq_t                 sq_d [RB+1];
  sq_t                 sq_q [RB+1];

  assign mm[0][0] = (W+2)'(in_i.m_r0_c0);
  assign mm[0][1] = (W+2)'(in_i.m_r0_c1);
  assign mm[0][2] = (W+2)'(in_i.m_r0_c2);
  assign mm[1][0] = (W+2)'(in_i.m_r1_c0);
  assign mm[1][1] = (W+2)'(in_i.m_r1_c1);
  assign mm[1][2] = (W+2)'(in_i.m_r1_c2);
  assign mm[2][0] = (W+2)'(in_i.m_r2_c0);
  assign mm[2][1] = (W+2)'(in_i.m_r2_c1);
  assign mm[2][2] = (W+2)'(in_i.m_r2_c2);

  always_comb begin
    tr = mm[0][0] + mm[1][1] + mm[2][2];
    // ties keep the lower axis
    ax = rmq_pkg::AxisX;
    if (mm[1][1] > mm[0][0]) ax = rmq_pkg::AxisY;
    if (mm[2][2] > mm[ax][ax]) ax = rmq_pkg::AxisZ;
    aj = rmq_pkg::next_axis(ax);
    ak = rmq_pkg::next_axis(aj);
    sq_d[0] = '0;
    if (tr > 0) begin
      t_val = tr + One;
      dd[0] = mm[2][1] - mm[1][2];
      dd[1] = mm[0][2] - mm[2][0];
      dd[2] = mm[1][0] - mm[0][1];
      sq_d[0].place = rmq_pkg::AxisW;
    end else begin
      t_val = mm[ax][ax] - (mm[aj][aj] + mm[ak][ak]) + One;
      dd[0] = mm[ak][aj] - mm[aj][ak];
      dd[1] = mm[aj][ax] + mm[ax][aj];
      dd[2] = mm[ak][ax] + mm[ax][ak];
      sq_d[0].place = ax;
    end
    for (int a = 0; a < 3; a++) begin
      sq_d[0].neg[a] = dd[a][W+1];
      sq_d[0].mag[a] = dd[a][W+1] ? (W+1)'(0) - dd[a][W:0] : dd[a][W:0];
    end
    // radicand scaled so one root gives both s and s/2
    sq_d[0].rem = (t_val > 0) ? (YW'(t_val[W:0]) << (F + 2)) : '0;
  end

  always_ff @(posedge clk_i) begin
    if (ry[0]) sq_q[0] <= sq_d[0];
  end

  // square root, one bit a stage
  for (genvar k = 1; k <= RB; k++) begin : g_sqrt
    localparam int unsigned B = RB - k;
    logic [YW-1:0] trial;
    always_comb begin
      trial   = (YW'(sq_q[k-1].root) << (B + 1)) + (YW'(1) << (2 * B));
      sq_d[k] = sq_q[k-1];
      if (sq_q[k-1].rem >= trial) begin
        sq_d[k].rem  = sq_q[k-1].rem - trial;
        sq_d[k].root = sq_q[k-1].root | (RB'(1) << B);
      end
    end
    always_ff @(posedge clk_i) begin
      if (ry[k]) sq_q[k] <= sq_d[k];
    end
  end

  // root to s, s/2 and numerators
  dv_t          dv_d [W+2];
  dv_t          dv_q [W+2];
  logic [RB:0]  r1, r2;
  logic [RB-1:0] s_fix;

  always_comb begin
    r1    = (RB+1)'(sq_q[RB].root) + (RB+1)'(1);
    r2    = (RB+1)'(sq_q[RB].root) + (RB+1)'(2);
    s_fix = r1[RB:1];
    dv_d[0]       = '0;
    dv_d[0].den   = {s_fix, 2'b00};
    dv_d[0].half  = r2[RB:2];
    dv_d[0].zero  = (sq_q[RB].root == '0);
    dv_d[0].neg   = sq_q[RB].neg;
    dv_d[0].place = sq_q[RB].place;
    for (int a = 0; a < 3; a++) begin
      dv_d[0].rem[a] = (NW'(sq_q[RB].mag[a]) << (F + 1)) + NW'({s_fix, 1'b0});
    end
  end

  always_ff @(posedge clk_i) begin
    if (ry[RB+1]) dv_q[0] <= dv_d[0];
  end

  // quotient too large for W bits
  always_comb begin
    dv_d[1] = dv_q[0];
    for (int a = 0; a < 3; a++) begin
      dv_d[1].ovf[a] = dv_q[0].rem[a] >= (NW'(dv_q[0].den) << W);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ry[RB+2]) dv_q[1] <= dv_d[1];
  end

  // restoring division, one quotient bit a stage
  for (genvar n = 2; n <= W + 1; n++) begin : g_div
    localparam int unsigned B = W + 1 - n;
    logic [NW-1:0] sub;
    always_comb begin
      sub     = NW'(dv_q[n-1].den) << B;
      dv_d[n] = dv_q[n-1];
      for (int a = 0; a < 3; a++) begin
        if (dv_q[n-1].rem[a] >= sub) begin
          dv_d[n].rem[a]    = dv_q[n-1].rem[a] - sub;
          dv_d[n].quo[a][B] = 1'b1;
        end
      end
    end
    always_ff @(posedge clk_i) begin
      if (ry[RB+1+n]) dv_q[n] <= dv_d[n];
    end
  end

  // clip and place
  function automatic logic [W:0] clip(input logic neg, input logic ovf,
                                      input logic [W-1:0] mag);
    logic [W:0] r;
    if (!neg) begin
      r = (ovf || mag > CompMax) ? {1'b1, CompMax} : {1'b0, mag};
    end else begin
      r = (ovf || mag > CompMinMag) ? {1'b1, CompMinMag} : {1'b0, W'(0) - mag};
    end
    return r;
  endfunction

  logic [W:0]   comp [3];
  logic [W:0]   hc;
  logic [W-1:0] vals [4];
  logic [3:0]   sats;
  rmq_pkg::quat_t out_d, out_q;
  rmq_pkg::axis_e pj, pk;

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      comp[a] = dv_q[W+1].zero ? '0
              : clip(dv_q[W+1].neg[a], dv_q[W+1].ovf[a], dv_q[W+1].quo[a]);
    end
    hc = clip(1'b0, 1'b0, dv_q[W+1].half);
    pj = rmq_pkg::next_axis(dv_q[W+1].place);
    pk = rmq_pkg::next_axis(pj);
    for (int a = 0; a < 4; a++) begin
      vals[a] = '0;
      sats[a] = 1'b0;
    end
    if (dv_q[W+1].place == rmq_pkg::AxisW) begin
      {sats[3], vals[3]} = hc;
      {sats[0], vals[0]} = comp[0];
      {sats[1], vals[1]} = comp[1];
      {sats[2], vals[2]} = comp[2];
    end else begin
      {sats[dv_q[W+1].place], vals[dv_q[W+1].place]} = hc;
      {sats[3], vals[3]}   = comp[0];
      {sats[pj], vals[pj]} = comp[1];
      {sats[pk], vals[pk]} = comp[2];
    end
    out_d.quat_x    = vals[0];
    out_d.quat_y    = vals[1];
    out_d.quat_z    = vals[2];
    out_d.quat_w    = vals[3];
    out_d.saturated = |sats;
  end

  always_ff @(posedge clk_i) begin
    if (ry[NST-1]) out_q <= out_d;
  end

  assign out_o = out_q;

  `RMQ_ASSERT(a_root_floor, vq[RB] |-> ((YW+1)'(sq_q[RB].rem) <= ((YW+1)'(sq_q[RB].root) << 1)), "square root remainder too large")
  `RMQ_ASSERT(a_full_stall, !ry[0] |-> (&vq), "input stalled with an empty stage")
  `RMQ_ASSERT(a_enter, (in_valid_i && in_ready_o) |=> vq[0], "accepted request lost at entry")
  `RMQ_ASSERT(a_quot_fits, (vq[RB+2] && !dv_q[1].ovf[0]) |-> (dv_q[1].rem[0] < (NW'(dv_q[1].den) << W)), "quotient overflow missed")

endmodule
